>>> hw/rtl/pdi_pkg.sv
// shared types, constants and config codes for the parking distance indicator
package pdi_pkg;

  // distance scale: cm = echo_us * SCALE_NUM / SCALE_DEN, never divided out
  localparam int unsigned ECHO_W   = 15;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RANGE_W  = 9;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned BAR_W    = 3;
  localparam int unsigned RUN_W    = 4;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned SCALED_W = 24;

  localparam logic [SCALED_W-1:0] SCALE_NUM = SCALED_W'(343);
  localparam logic [SCALED_W-1:0] SCALE_DEN = SCALED_W'(20000);

  // zone edges in scaled units (cm * SCALE_DEN)
  localparam logic [SCALED_W-1:0] ZONE_45_CM = SCALED_W'(45 * 20000);
  localparam logic [SCALED_W-1:0] ZONE_30_CM = SCALED_W'(30 * 20000);
  localparam logic [SCALED_W-1:0] ZONE_20_CM = SCALED_W'(20 * 20000);
  localparam logic [SCALED_W-1:0] ZONE_15_CM = SCALED_W'(15 * 20000);
  localparam logic [SCALED_W-1:0] ZONE_10_CM = SCALED_W'(10 * 20000);
  localparam logic [SCALED_W-1:0] ZONE_5_CM  = SCALED_W'(5 * 20000);

  // config reset values
  localparam logic [SCALED_W-1:0] MIN_THR_RESET    = SCALED_W'(2 * 20000);
  localparam logic [SCALED_W-1:0] MAX_THR_RESET    = SCALED_W'(150 * 20000);
  localparam logic [LIMIT_W-1:0]  FAIL_LIMIT_RESET = LIMIT_W'(3);
  localparam logic [RUN_W-1:0]    RUN_MAX          = {RUN_W{1'b1}};

  // config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RANGE  = 2'd0,
    CFG_MAX_RANGE  = 2'd1,
    CFG_FAIL_LIMIT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [ECHO_W-1:0] echo_us;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [BAR_W-1:0] led_count;
    logic             buzzer_on;
    logic             reading_valid;
  } out_item_t;

  // thresholds are kept pre-scaled so the datapath only compares
  typedef struct packed {
    logic [SCALED_W-1:0] min_thr;
    logic [SCALED_W-1:0] max_thr;
    logic [LIMIT_W-1:0]  fail_limit;
  } cfg_t;

  typedef struct packed {
    logic [BAR_W-1:0]  bar_level;
    logic              tone_active;
    logic [TIME_W-1:0] last_toggle_ms;
    logic [RUN_W-1:0]  failure_run;
  } pdi_state_t;

endpackage

>>> hw/rtl/pdi_eval.sv
// one reading: range check, zone lookup, beeper timing and next state
module pdi_eval (
  input  pdi_pkg::in_item_t   item,
  input  pdi_pkg::cfg_t       cfg,
  input  pdi_pkg::pdi_state_t state,
  output pdi_pkg::pdi_state_t state_next,
  output pdi_pkg::out_item_t  result
);

  logic [pdi_pkg::SCALED_W-1:0] scaled;
  logic                         valid;
  logic [pdi_pkg::BAR_W-1:0]    zone_bar;
  logic [pdi_pkg::PERIOD_W-1:0] on_ms;
  logic [pdi_pkg::PERIOD_W-1:0] off_ms;
  logic [pdi_pkg::TIME_W-1:0]   elapsed;
  logic [pdi_pkg::RUN_W-1:0]    run_inc;
  logic                         tone_want;

  assign scaled = pdi_pkg::SCALED_W'(item.echo_us) * pdi_pkg::SCALE_NUM;
  assign valid  = (item.echo_us != '0) && (scaled >= cfg.min_thr)
                  && (scaled <= cfg.max_thr);
  assign elapsed = item.now_ms - state.last_toggle_ms;
  assign run_inc = (state.failure_run == pdi_pkg::RUN_MAX) ? state.failure_run
                   : state.failure_run + pdi_pkg::RUN_W'(1);

  // zone table, far to near
  always_comb begin
    if (scaled > pdi_pkg::ZONE_45_CM) begin
      zone_bar = 3'd0; on_ms = 10'd0;   off_ms = 10'd0;
    end else if (scaled > pdi_pkg::ZONE_30_CM) begin
      zone_bar = 3'd1; on_ms = 10'd100; off_ms = 10'd900;
    end else if (scaled > pdi_pkg::ZONE_20_CM) begin
      zone_bar = 3'd2; on_ms = 10'd100; off_ms = 10'd650;
    end else if (scaled > pdi_pkg::ZONE_15_CM) begin
      zone_bar = 3'd3; on_ms = 10'd100; off_ms = 10'd450;
    end else if (scaled > pdi_pkg::ZONE_10_CM) begin
      zone_bar = 3'd4; on_ms = 10'd90;  off_ms = 10'd300;
    end else if (scaled > pdi_pkg::ZONE_5_CM) begin
      zone_bar = 3'd5; on_ms = 10'd70;  off_ms = 10'd150;
    end else begin
      zone_bar = 3'd6; on_ms = 10'd50;  off_ms = 10'd50;
    end
  end

  always_comb begin
    state_next = state;
    tone_want  = state.tone_active;
    if (!valid) begin
      state_next.failure_run = run_inc;
      tone_want = 1'b0;
      if (run_inc >= cfg.fail_limit) begin
        state_next.bar_level = '0;
      end
    end else begin
      state_next.failure_run = '0;
      state_next.bar_level   = zone_bar;
      if (zone_bar == '0) begin
        tone_want = 1'b0;
      end else if (state.tone_active) begin
        if (elapsed >= pdi_pkg::TIME_W'(on_ms)) begin
          tone_want = 1'b0;
        end
      end else begin
        if (elapsed >= pdi_pkg::TIME_W'(off_ms)) begin
          tone_want = 1'b1;
        end
      end
    end
    // only a real change of the tone restarts its timer
    if (tone_want != state.tone_active) begin
      state_next.tone_active    = tone_want;
      state_next.last_toggle_ms = item.now_ms;
    end
  end

  assign result.led_count     = state_next.bar_level;
  assign result.buzzer_on     = state_next.tone_active;
  assign result.reading_valid = valid;

endmodule

>>> hw/rtl/parking_distance_indicator_unit.sv
// top level of the parking distance indicator: handshake, config and state registers
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | input     | in_valid/in_stall  | in_data  (echo_us, now_ms)
//   out     | output    | out_valid/out_stall| out_data (led_count, buzzer_on,
//           |           |                    |           reading_valid)
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one beat per cycle while out_stall is low; an accepted beat reaches out_valid
// via the input register, then the result register after one pass through pdi_eval
// the block state is updated in the same cycle the result register loads
// rst is synchronous: clears handshake flags, block state and config to defaults
// out_stall holds the result register; in_stall rises only when the input register
// is full and its beat cannot move on
module parking_distance_indicator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pdi_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pdi_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [pdi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdi_pkg::RANGE_W-1:0]         cfg_wdata
);

  // input register
  logic               in_full;
  pdi_pkg::in_item_t  in_reg;

  // config and block state
  pdi_pkg::cfg_t      cfg;
  pdi_pkg::pdi_state_t state;
  pdi_pkg::pdi_state_t state_next;
  pdi_pkg::out_item_t result;

  logic advance;
  logic in_take;

  // the held beat moves on when the result register is empty or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  pdi_eval u_eval (
    .item       (in_reg),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  // result register and block state move together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      out_valid <= in_full;
      if (in_full) begin
        state <= state_next;
      end
    end
    if (advance && in_full) begin
      out_data <= result;
    end
  end

  // config writes; range limits are stored pre-scaled by the cm factor
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_thr    <= pdi_pkg::MIN_THR_RESET;
      cfg.max_thr    <= pdi_pkg::MAX_THR_RESET;
      cfg.fail_limit <= pdi_pkg::FAIL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (pdi_pkg::cfg_index_t'(cfg_index))
        pdi_pkg::CFG_MIN_RANGE: begin
          cfg.min_thr <= pdi_pkg::SCALED_W'(cfg_wdata) * pdi_pkg::SCALE_DEN;
        end
        pdi_pkg::CFG_MAX_RANGE: begin
          cfg.max_thr <= pdi_pkg::SCALED_W'(cfg_wdata) * pdi_pkg::SCALE_DEN;
        end
        pdi_pkg::CFG_FAIL_LIMIT: begin
          cfg.fail_limit <= cfg_wdata[pdi_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/pdi_checker.sv
// port-level checks for the parking distance indicator, bound to the top level
module pdi_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input pdi_pkg::out_item_t out_data
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");

  // a failed reading always silences the beeper
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.reading_valid |-> !out_data.buzzer_on)
    else $error("beeper on after failed reading");

  // a valid reading with an empty bar is beyond the beeper zone
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reading_valid && (out_data.led_count == 3'd0)
    |-> !out_data.buzzer_on)
    else $error("beeper on beyond the far zone");

  // the bar never exceeds six segments
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.led_count <= 3'd6)
    else $error("bar count out of range");

endmodule

bind parking_distance_indicator_unit pdi_checker u_pdi_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/testbench.sv
// self-checking testbench for parking_distance_indicator_unit: directed table, then random readings
module testbench;

  localparam int PERIOD         = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 200000;
  // covers the input and result registers from acceptance to out_valid, plus margin
  localparam int TAIL_CYCLES    = 4;
  localparam int PHASES         = 8;
  localparam int BEATS_PER_PHASE = 50;
  localparam int unsigned IDLE_MAX = 14;

  // index with no register behind it, writes to it are dropped
  localparam logic [pdi_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // distance in cm is echo_us * ECHO_SCALE / CM_SCALE, kept as a cross-multiplied compare
  localparam longint unsigned ECHO_SCALE = 343;
  localparam longint unsigned CM_SCALE   = 20000;
  localparam logic [pdi_pkg::RUN_W-1:0] RUN_CAP = 4'd15;

  localparam pdi_pkg::out_item_t SILENT_FAIL =
    '{led_count: 3'd0, buzzer_on: 1'b0, reading_valid: 1'b0};
  localparam pdi_pkg::out_item_t FAR_VALID =
    '{led_count: 3'd0, buzzer_on: 1'b0, reading_valid: 1'b1};
  localparam pdi_pkg::out_item_t HELD_FIVE =
    '{led_count: 3'd5, buzzer_on: 1'b0, reading_valid: 1'b0};
  localparam pdi_pkg::out_item_t UNTYPED = '0;

  typedef struct packed {
    logic [pdi_pkg::ECHO_W-1:0] echo;
    logic [pdi_pkg::TIME_W-1:0] stamp;
    logic                       typed;
    pdi_pkg::out_item_t         want;
  } table_row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  pdi_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  pdi_pkg::out_item_t            out_data;
  logic                          cfg_wr_en;
  logic [pdi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pdi_pkg::RANGE_W-1:0]   cfg_wdata;

  parking_distance_indicator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // directed readings under the reset config (min 2 cm, max 150 cm, limit 3);
  // rows with typed set carry a result read straight off the spec, the rest use the predictor
  table_row_t reading_table [0:25] = '{
    '{15'd0,     32'd0,          1'b1, SILENT_FAIL},  // no echo
    '{15'd32767, 32'd5,          1'b1, SILENT_FAIL},  // largest echo, far beyond max range
    '{15'd8746,  32'd10,         1'b1, FAR_VALID},    // just inside 150 cm, beyond 45 cm
    '{15'd8747,  32'd20,         1'b1, SILENT_FAIL},  // just past 150 cm
    '{15'd116,   32'd30,         1'b1, SILENT_FAIL},  // just under 2 cm
    '{15'd117,   32'd1000,       1'b0, UNTYPED},      // just at 2 cm, nearest zone, tone on
    '{15'd117,   32'd1049,       1'b0, UNTYPED},      // one ms short of the on time
    '{15'd117,   32'd1050,       1'b0, UNTYPED},      // on time reached, tone off
    '{15'd291,   32'd1100,       1'b0, UNTYPED},      // upper edge of the 5 cm zone
    '{15'd292,   32'd1300,       1'b0, UNTYPED},      // lower edge of the 10 cm zone
    '{15'd583,   32'd1400,       1'b0, UNTYPED},
    '{15'd584,   32'd1800,       1'b0, UNTYPED},
    '{15'd874,   32'd2200,       1'b0, UNTYPED},
    '{15'd875,   32'd2700,       1'b0, UNTYPED},
    '{15'd1166,  32'd3200,       1'b0, UNTYPED},
    '{15'd1167,  32'd4000,       1'b0, UNTYPED},
    '{15'd1749,  32'd5000,       1'b0, UNTYPED},
    '{15'd1750,  32'd6000,       1'b0, UNTYPED},
    '{15'd2623,  32'd7000,       1'b0, UNTYPED},      // last echo that lights one LED
    '{15'd2624,  32'd8000,       1'b0, UNTYPED},      // past 45 cm, beeper forced off
    '{15'd300,   32'd9000,       1'b0, UNTYPED},      // five LEDs lit
    '{15'd0,     32'd9010,       1'b1, HELD_FIVE},    // failures below the limit hold the bar
    '{15'd0,     32'd9020,       1'b1, HELD_FIVE},
    '{15'd0,     32'd9030,       1'b1, SILENT_FAIL},  // third failure clears the bar
    '{15'd300,   32'hFFFF_FFF0,  1'b0, UNTYPED},      // timestamp about to wrap
    '{15'd300,   32'h0000_0040,  1'b0, UNTYPED}       // elapsed time across the wrap
  };

  // predictor copy of config and block state
  longint unsigned min_cm;
  longint unsigned max_cm;
  logic [pdi_pkg::LIMIT_W-1:0] clear_limit;
  logic [pdi_pkg::BAR_W-1:0]   bar;
  logic                        tone;
  logic [pdi_pkg::TIME_W-1:0]  last_toggle;
  logic [pdi_pkg::RUN_W-1:0]   fail_run;

  pdi_pkg::out_item_t pending_results [$];
  int unsigned fail_count;
  int unsigned tx_idle_max;
  int unsigned rx_idle_max;
  logic [pdi_pkg::TIME_W-1:0] clock_ms;
  int unsigned fail_burst;

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(PERIOD * TIMEOUT_CYCLES);
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report(string msg);
    fail_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // only a real change of the tone moves the toggle stamp
  function automatic void move_tone(logic on, logic [pdi_pkg::TIME_W-1:0] stamp);
    if (tone != on) begin
      tone = on;
      last_toggle = stamp;
    end
  endfunction

  function automatic pdi_pkg::out_item_t predict_reading(pdi_pkg::in_item_t beat);
    longint unsigned scaled;
    logic in_range;
    int unsigned on_ms;
    int unsigned off_ms;
    logic [pdi_pkg::TIME_W-1:0] elapsed;
    pdi_pkg::out_item_t res;
    scaled = longint'(beat.echo_us) * ECHO_SCALE;
    in_range = beat.echo_us != '0 && scaled >= min_cm * CM_SCALE
               && scaled <= max_cm * CM_SCALE;
    if (!in_range) begin
      if (fail_run != RUN_CAP) fail_run++;
      move_tone(1'b0, beat.now_ms);
      if (fail_run >= clear_limit) bar = '0;
    end else begin
      fail_run = '0;
      if (scaled > 45 * CM_SCALE) begin
        bar = '0;
        move_tone(1'b0, beat.now_ms);
      end else begin
        if (scaled > 30 * CM_SCALE) begin
          bar = 3'd1; on_ms = 100; off_ms = 900;
        end else if (scaled > 20 * CM_SCALE) begin
          bar = 3'd2; on_ms = 100; off_ms = 650;
        end else if (scaled > 15 * CM_SCALE) begin
          bar = 3'd3; on_ms = 100; off_ms = 450;
        end else if (scaled > 10 * CM_SCALE) begin
          bar = 3'd4; on_ms = 90; off_ms = 300;
        end else if (scaled > 5 * CM_SCALE) begin
          bar = 3'd5; on_ms = 70; off_ms = 150;
        end else begin
          bar = 3'd6; on_ms = 50; off_ms = 50;
        end
        // unsigned wrapping difference
        elapsed = beat.now_ms - last_toggle;
        if (tone) begin
          if (elapsed >= on_ms) move_tone(1'b0, beat.now_ms);
        end else begin
          if (elapsed >= off_ms) move_tone(1'b1, beat.now_ms);
        end
      end
    end
    res.led_count = bar;
    res.buzzer_on = tone;
    res.reading_valid = in_range;
    return res;
  endfunction

  // leaves cfg_wr_en high; the caller lowers it once after the last write
  task automatic write_reg(logic [pdi_pkg::CFG_IDX_W-1:0] idx,
                           logic [pdi_pkg::RANGE_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      pdi_pkg::CFG_MIN_RANGE:  min_cm = 64'(value);
      pdi_pkg::CFG_MAX_RANGE:  max_cm = 64'(value);
      pdi_pkg::CFG_FAIL_LIMIT: clear_limit = value[pdi_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // valid stays high after acceptance so back-to-back beats need no extra edge
  task automatic send_beat(pdi_pkg::in_item_t beat, logic typed, pdi_pkg::out_item_t want,
                           int unsigned gap);
    pdi_pkg::out_item_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    predicted = predict_reading(beat);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // mostly echoes inside the zones, plus no-echo, range edges and wild values
  function automatic logic [pdi_pkg::ECHO_W-1:0] pick_echo();
    int v;
    if (fail_burst != 0) begin
      fail_burst--;
      // beyond 511 cm, so it fails under any range setting
      return ($urandom_range(0, 1) == 0) ? '0
             : pdi_pkg::ECHO_W'($urandom_range(30000, 32767));
    end
    case ($urandom_range(0, 15))
      0: v = 0;
      1: v = $urandom_range(0, 32767);
      2: v = int'(max_cm * CM_SCALE / ECHO_SCALE) + $urandom_range(0, 4) - 2;
      3: v = int'(min_cm * CM_SCALE / ECHO_SCALE) + $urandom_range(0, 4) - 2;
      4: v = $urandom_range(2625, 30000);
      5: begin
        fail_burst = $urandom_range(1, 18);
        v = 0;
      end
      default: v = $urandom_range(1, 2700);
    endcase
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return pdi_pkg::ECHO_W'(v);
  endfunction

  function automatic logic [pdi_pkg::TIME_W-1:0] advance_clock();
    if ($urandom_range(0, 24) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 320);
    return clock_ms;
  endfunction

  // result side: random stall per beat, checked against the oldest expectation
  initial begin
    int unsigned hold;
    pdi_pkg::out_item_t want;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result %p with nothing expected", out_data));
        end else begin
          want = pending_results.pop_front();
          if (out_data.led_count !== want.led_count)
            report($sformatf("led_count %0d, expected %0d", out_data.led_count,
                             want.led_count));
          if (out_data.buzzer_on !== want.buzzer_on)
            report($sformatf("buzzer_on %b, expected %b", out_data.buzzer_on,
                             want.buzzer_on));
          if (out_data.reading_valid !== want.reading_valid)
            report($sformatf("reading_valid %b, expected %b", out_data.reading_valid,
                             want.reading_valid));
        end
        hold = $urandom_range(0, rx_idle_max);
      end else if (out_valid && hold != 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  initial begin
    pdi_pkg::in_item_t beat;
    fail_count = 0;
    fail_burst = 0;
    tx_idle_max = IDLE_MAX;
    rx_idle_max = IDLE_MAX;
    min_cm = 2;
    max_cm = 150;
    clear_limit = 4'd3;
    bar = '0;
    tone = 1'b0;
    last_toggle = '0;
    fail_run = '0;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= pdi_pkg::CFG_MIN_RANGE;
    cfg_wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset config
    foreach (reading_table[i]) begin
      beat.echo_us = reading_table[i].echo;
      beat.now_ms = reading_table[i].stamp;
      send_beat(beat, reading_table[i].typed, reading_table[i].want,
                $urandom_range(0, tx_idle_max));
    end
    wait_results_drained();

    // random phases, each under its own config; the first few are corner settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_SPARE, '1);
          // high bits above the limit's width get dropped, leaving 2
          write_reg(pdi_pkg::CFG_FAIL_LIMIT, 9'h1F2);
        end
        1: begin
          write_reg(pdi_pkg::CFG_MIN_RANGE, '0);
          write_reg(pdi_pkg::CFG_MAX_RANGE, '1);
          write_reg(pdi_pkg::CFG_FAIL_LIMIT, '0);
        end
        2: begin
          // inverted range: every reading fails
          write_reg(pdi_pkg::CFG_MIN_RANGE, 9'd400);
          write_reg(pdi_pkg::CFG_MAX_RANGE, '0);
          write_reg(pdi_pkg::CFG_FAIL_LIMIT, 9'd15);
        end
        3: begin
          write_reg(pdi_pkg::CFG_MIN_RANGE, '0);
          write_reg(pdi_pkg::CFG_MAX_RANGE, '0);
          write_reg(pdi_pkg::CFG_FAIL_LIMIT, 9'd1);
        end
        4: begin
          write_reg(pdi_pkg::CFG_MIN_RANGE, 9'd10);
          write_reg(pdi_pkg::CFG_MAX_RANGE, 9'd45);
          write_reg(pdi_pkg::CFG_FAIL_LIMIT, 9'd15);
        end
        default: begin
          write_reg(pdi_pkg::CFG_MIN_RANGE, pdi_pkg::RANGE_W'($urandom_range(0, 30)));
          write_reg(pdi_pkg::CFG_MAX_RANGE, pdi_pkg::RANGE_W'($urandom_range(30, 400)));
          write_reg(pdi_pkg::CFG_FAIL_LIMIT, pdi_pkg::RANGE_W'($urandom_range(1, 15)));
        end
      endcase
      cfg_wr_en <= 1'b0;

      // some phases run with one side never idling
      tx_idle_max = (p % 3 == 1) ? 0 : IDLE_MAX;
      rx_idle_max = (p % 4 == 2) ? 0 : IDLE_MAX;
      // start each phase, with even odds, just short of the timestamp wrap
      if ($urandom_range(0, 1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else clock_ms = $urandom;
      fail_burst = 0;

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        beat.echo_us = pick_echo();
        beat.now_ms = advance_clock();
        send_beat(beat, 1'b0, UNTYPED, $urandom_range(0, tx_idle_max));
        // now and then hold the sender until the pipeline is empty
        if ($urandom_range(0, 29) == 0) wait_results_drained();
      end
      wait_results_drained();
    end

    if (pending_results.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
